### rtl/core/plcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcc_pkg
// Shared types, codes and constants of the pixel lookup color converter.
// ----------------------------------------------------------------------------
package plcc_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned ValW   = 16;
  localparam int unsigned DensW  = 18;
  localparam int unsigned LumW   = 15;
  localparam int unsigned LumPW  = 23;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ChanW-1:0] ChanMax      = 8'd255;
  localparam logic [ValW-1:0]  ValMax       = 16'd65535;
  localparam logic [DensW-1:0] DensityUnity = 18'd65536;

  // luminance weights, sum is 100
  localparam int unsigned LumR = 31;
  localparam int unsigned LumG = 61;
  localparam int unsigned LumB = 8;

  // luminance * alpha / 25500 by reciprocal: floor(2^26 / 25500)
  localparam int unsigned LumDiv    = 25500;
  localparam int unsigned LumRecip  = 2631;
  localparam int unsigned LumShift  = 26;

  typedef enum logic [1:0] {
    MODE_RGB2RGB   = 2'd0,
    MODE_RGB2GRAY  = 2'd1,
    MODE_GRAY2GRAY = 2'd2,
    MODE_GRAY2RGB  = 2'd3
  } mode_e;

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_WRITE   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    TAB_COMP  = 2'd0,
    TAB_RED   = 2'd1,
    TAB_GREEN = 2'd2,
    TAB_BLUE  = 2'd3
  } tab_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE       = 2'd0,
    CFG_HAS_ALPHA  = 2'd1,
    CFG_DENSITY    = 2'd2,
    CFG_MONOCHROME = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    mode_e             mode;
    logic              has_alpha;
    logic [DensW-1:0]  density;
    logic              monochrome;
  } cfg_t;

  // table access issued by the index pipeline
  typedef struct packed {
    logic              valid;
    logic              wr;
    tab_e              sel;
    logic [ChanW-1:0]  idx_a;
    logic [ChanW-1:0]  idx_b;
    logic [ChanW-1:0]  idx_c;
    logic [ValW-1:0]   wdata;
    logic              last;
  } lut_req_t;

  // registered table read data
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ValW-1:0]   comp;
    logic [ValW-1:0]   red;
    logic [ValW-1:0]   green;
    logic [ValW-1:0]   blue;
  } lut_rsp_t;

  // exact floor(x / 255) for x up to 255 * 255
  function automatic logic [ChanW-1:0] div255(input logic [ValW-1:0] x);
    logic [ValW:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

### rtl/core/plcc_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcc_index
// Four-stage pipeline that blends against white and forms the table indexes.
// ----------------------------------------------------------------------------
module plcc_index import plcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             in_valid_i,
  input  cfg_t             cfg_i,
  input  logic             opcode_i,
  input  logic [ChanW-1:0] chan_a_i,
  input  logic [ChanW-1:0] chan_b_i,
  input  logic [ChanW-1:0] chan_c_i,
  input  logic [ChanW-1:0] alpha_i,
  input  logic             last_pixel_i,
  input  logic [1:0]       table_select_i,
  input  logic [ChanW-1:0] table_index_i,
  input  logic [ValW-1:0]  table_value_i,
  output lut_req_t         req_o
);

  // control common to all stages
  typedef struct packed {
    op_e              op;
    logic             last;
    tab_e             sel;
    logic [ChanW-1:0] tidx;
    logic [ValW-1:0]  tval;
  } ctl_t;

  logic v1_q, v2_q, v3_q, v4_q;
  ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;

  // stage 1: raw fields
  logic [ChanW-1:0] ca1_q, cb1_q, cc1_q, al1_q;
  logic [ChanW-1:0] eal1;
  logic [ValW-1:0]  pa_d, pb_d, pc_d;
  logic [LumW-1:0]  lum_d;

  // stage 2: products
  logic [ValW-1:0]  pa2_q, pb2_q, pc2_q;
  logic [LumW-1:0]  lum2_q;
  logic [ChanW-1:0] eal2_q;
  logic [ChanW-1:0] bla_d, blb_d, blc_d;
  logic [LumPW-1:0] lump_d;

  // stage 3: blended channels, weighted luminance
  logic [ChanW-1:0] bla3_q, blb3_q, blc3_q, eal3_q;
  logic [LumPW-1:0] lump3_q;
  logic [34:0]      qprod;
  logic [ChanW-1:0] qe_d;

  // stage 4: quotient estimate and correction
  logic [ChanW-1:0] bla4_q, blb4_q, blc4_q, eal4_q, qe4_q;
  logic [LumPW-1:0] lump4_q;
  logic [LumPW-1:0] rem;
  logic [ChanW-1:0] q_fix, lidx;
  logic [ChanW-1:0] idx_a, idx_b, idx_c;

  // no alpha behaves as fully opaque
  assign eal1 = cfg_i.has_alpha ? al1_q : ChanMax;
  assign pa_d = ValW'(ca1_q) * ValW'(eal1);
  assign pb_d = ValW'(cb1_q) * ValW'(eal1);
  assign pc_d = ValW'(cc1_q) * ValW'(eal1);
  assign lum_d = LumW'(ca1_q) * LumW'(LumR) + LumW'(cb1_q) * LumW'(LumG)
               + LumW'(cc1_q) * LumW'(LumB);

  assign bla_d  = div255(pa2_q) + (ChanMax - eal2_q);
  assign blb_d  = div255(pb2_q) + (ChanMax - eal2_q);
  assign blc_d  = div255(pc2_q) + (ChanMax - eal2_q);
  // lum / 100 equals lum * 255 / 25500, so one path serves both cases
  assign lump_d = LumPW'(lum2_q) * LumPW'(eal2_q);

  assign qprod = 35'(lump3_q) * 35'(LumRecip);
  assign qe_d  = qprod[LumShift +: ChanW];

  // estimate is low by at most one
  assign rem   = lump4_q - LumPW'(qe4_q) * LumPW'(LumDiv);
  assign q_fix = qe4_q + ChanW'(rem >= LumPW'(LumDiv));
  assign lidx  = q_fix + (ChanMax - eal4_q);

  always_comb begin
    case (cfg_i.mode)
      MODE_RGB2RGB: begin
        idx_a = bla4_q;
        idx_b = blb4_q;
        idx_c = blc4_q;
      end
      MODE_RGB2GRAY: begin
        idx_a = lidx;
        idx_b = lidx;
        idx_c = lidx;
      end
      default: begin
        idx_a = bla4_q;
        idx_b = bla4_q;
        idx_c = bla4_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl1_q  <= '{op: op_e'(opcode_i), last: last_pixel_i, sel: tab_e'(table_select_i),
                   tidx: table_index_i, tval: table_value_i};
      ca1_q   <= chan_a_i;
      cb1_q   <= chan_b_i;
      cc1_q   <= chan_c_i;
      al1_q   <= alpha_i;

      ctl2_q  <= ctl1_q;
      pa2_q   <= pa_d;
      pb2_q   <= pb_d;
      pc2_q   <= pc_d;
      lum2_q  <= lum_d;
      eal2_q  <= eal1;

      ctl3_q  <= ctl2_q;
      bla3_q  <= bla_d;
      blb3_q  <= blb_d;
      blc3_q  <= blc_d;
      lump3_q <= lump_d;
      eal3_q  <= eal2_q;

      ctl4_q  <= ctl3_q;
      bla4_q  <= bla3_q;
      blb4_q  <= blb3_q;
      blc4_q  <= blc3_q;
      lump4_q <= lump3_q;
      eal4_q  <= eal3_q;
      qe4_q   <= qe_d;
    end
  end

  always_comb begin
    req_o.valid = v4_q;
    req_o.wr    = (ctl4_q.op == OP_WRITE);
    req_o.sel   = ctl4_q.sel;
    req_o.idx_a = (ctl4_q.op == OP_WRITE) ? ctl4_q.tidx : idx_a;
    req_o.idx_b = idx_b;
    req_o.idx_c = idx_c;
    req_o.wdata = ctl4_q.tval;
    req_o.last  = ctl4_q.last;
  end

`ifndef ASSERT_OFF
  a_recip_within_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (rem < LumPW'(2 * LumDiv)))
    else $error("luminance quotient estimate off by more than one");
`endif

endmodule

### rtl/core/plcc_lut.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcc_lut
// Four 16-bit lookup tables: a write and a registered read per cycle if adv_i.
// ----------------------------------------------------------------------------
module plcc_lut import plcc_pkg::*; #(
  parameter int unsigned TableEntries = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  lut_req_t req_i,
  output lut_rsp_t rsp_o
);

  localparam int unsigned AddrW = $clog2(TableEntries);

  logic [ValW-1:0] comp_mem  [TableEntries];
  logic [ValW-1:0] red_mem   [TableEntries];
  logic [ValW-1:0] green_mem [TableEntries];
  logic [ValW-1:0] blue_mem  [TableEntries];

  logic [ValW-1:0] comp_rd_q, red_rd_q, green_rd_q, blue_rd_q;
  logic            valid_q, last_q;
  logic [AddrW-1:0] addr_a, addr_b, addr_c;
  logic            we;

  assign addr_a = req_i.idx_a[AddrW-1:0];
  assign addr_b = req_i.idx_b[AddrW-1:0];
  assign addr_c = req_i.idx_c[AddrW-1:0];
  assign we     = adv_i && req_i.valid && req_i.wr;

  // writes and reads leave this stage in item order, so a later read
  // always sees an earlier write
  always_ff @(posedge clk_i) begin
    if (we && req_i.sel == TAB_COMP) begin
      comp_mem[addr_a] <= req_i.wdata;
    end
    if (adv_i) begin
      comp_rd_q <= comp_mem[addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we && req_i.sel == TAB_RED) begin
      red_mem[addr_a] <= req_i.wdata;
    end
    if (adv_i) begin
      red_rd_q <= red_mem[addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we && req_i.sel == TAB_GREEN) begin
      green_mem[addr_a] <= req_i.wdata;
    end
    if (adv_i) begin
      green_rd_q <= green_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we && req_i.sel == TAB_BLUE) begin
      blue_mem[addr_a] <= req_i.wdata;
    end
    if (adv_i) begin
      blue_rd_q <= blue_mem[addr_c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= req_i.valid && !req_i.wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      last_q <= req_i.last;
    end
  end

  always_comb begin
    rsp_o.valid = valid_q;
    rsp_o.last  = last_q;
    rsp_o.comp  = comp_rd_q;
    rsp_o.red   = red_rd_q;
    rsp_o.green = green_rd_q;
    rsp_o.blue  = blue_rd_q;
  end

endmodule

### rtl/core/plcc_density.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcc_density
// Channel selection, density scaling with saturation, and the output register.
// ----------------------------------------------------------------------------
module plcc_density import plcc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  cfg_t            cfg_i,
  input  lut_rsp_t        rsp_i,
  output logic            out_valid_o,
  output logic [ValW-1:0] out_a_o,
  output logic [ValW-1:0] out_b_o,
  output logic [ValW-1:0] out_c_o,
  output logic            row_end_o
);

  logic [ValW-1:0]  va, vb, vc;
  logic             dens, gray;
  logic [33:0]      da_d, db_d, dc_d;

  logic             v6_q, last6_q, dens_a6_q, dens_bc6_q;
  logic [ValW-1:0]  va6_q, vb6_q, vc6_q;
  logic [DensW-1:0] da6_q, db6_q, dc6_q;
  logic [ValW-1:0]  ra, rb, rc;

  logic             out_valid_q, row_end_q;
  logic [ValW-1:0]  out_a_q, out_b_q, out_c_q;

  function automatic logic [ValW-1:0] dens_sat(input logic [DensW-1:0] drop);
    return (drop >= DensW'(ValMax)) ? '0 : ValMax - drop[ValW-1:0];
  endfunction

  always_comb begin
    case (cfg_i.mode)
      MODE_RGB2GRAY, MODE_GRAY2GRAY: begin
        gray = 1'b1;
        va   = rsp_i.comp;
        vb   = '0;
        vc   = '0;
        dens = !cfg_i.monochrome;
      end
      MODE_RGB2RGB: begin
        gray = 1'b0;
        va   = rsp_i.red;
        vb   = rsp_i.green;
        vc   = rsp_i.blue;
        dens = cfg_i.density < DensityUnity;
      end
      default: begin
        gray = 1'b0;
        va   = rsp_i.red;
        vb   = rsp_i.green;
        vc   = rsp_i.blue;
        dens = 1'b1;
      end
    endcase
  end

  assign da_d = 34'(ValMax - va) * 34'(cfg_i.density);
  assign db_d = 34'(ValMax - vb) * 34'(cfg_i.density);
  assign dc_d = 34'(ValMax - vc) * 34'(cfg_i.density);

  assign ra = dens_a6_q  ? dens_sat(da6_q) : va6_q;
  assign rb = dens_bc6_q ? dens_sat(db6_q) : vb6_q;
  assign rc = dens_bc6_q ? dens_sat(dc6_q) : vc6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      v6_q        <= rsp_i.valid;
      out_valid_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      last6_q    <= rsp_i.last;
      dens_a6_q  <= dens;
      dens_bc6_q <= dens && !gray;
      va6_q      <= va;
      vb6_q      <= vb;
      vc6_q      <= vc;
      da6_q      <= da_d[33:16];
      db6_q      <= db_d[33:16];
      dc6_q      <= dc_d[33:16];

      row_end_q  <= last6_q;
      out_a_q    <= ra;
      out_b_q    <= rb;
      out_c_q    <= rc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_a_o     = out_a_q;
  assign out_b_o     = out_b_q;
  assign out_c_o     = out_c_q;
  assign row_end_o   = row_end_q;

endmodule

### rtl/core/pixel_lut_color_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_lut_color_convert
// Gray or RGB pixel to 16-bit printer values through four lookup tables.
// ----------------------------------------------------------------------------
// Input words carry either a pixel to convert or a table entry to write;
// table writes yield no output word. Each converted pixel yields one output
// word (out_a/out_b/out_c plus row_end) in input order.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. Configuration registers are written through cfg_we_i/cfg_idx_i and
// must only change while the block is drained.
// Throughput: one word per cycle while the receiver does not stall, set by
// the single read and write port of each table; a table write followed
// directly by a read of the same entry needs no wait because both pass the
// table stage in order. When the receiver stalls with a word pending, the
// whole pipeline holds and in_stall_o rises in the same cycle; bubbles hold
// as well. Reset clears the valid bits and loads the register defaults (mode
// rgb to rgb, no alpha, unity density, not monochrome). Table contents are
// undefined until written; there is no clearing pass.
// ----------------------------------------------------------------------------
module pixel_lut_color_convert import plcc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DensW-1:0]   cfg_wdata_i,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [ChanW-1:0]   chan_a_i,
  input  logic [ChanW-1:0]   chan_b_i,
  input  logic [ChanW-1:0]   chan_c_i,
  input  logic [ChanW-1:0]   alpha_i,
  input  logic               last_pixel_i,
  input  logic [1:0]         table_select_i,
  input  logic [ChanW-1:0]   table_index_i,
  input  logic [ValW-1:0]    table_value_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ValW-1:0]    out_a_o,
  output logic [ValW-1:0]    out_b_o,
  output logic [ValW-1:0]    out_c_o,
  output logic               row_end_o
);

  cfg_t     cfg_q;
  logic     adv;
  lut_req_t lut_req;
  lut_rsp_t lut_rsp;

  // pipeline moves unless a finished word is held by the receiver
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_RGB2RGB, has_alpha: 1'b0, density: DensityUnity,
                 monochrome: 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:       cfg_q.mode       <= mode_e'(cfg_wdata_i[1:0]);
        CFG_HAS_ALPHA:  cfg_q.has_alpha  <= cfg_wdata_i[0];
        CFG_DENSITY:    cfg_q.density    <= cfg_wdata_i;
        CFG_MONOCHROME: cfg_q.monochrome <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  plcc_index u_index (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .in_valid_i     (in_valid_i),
    .cfg_i          (cfg_q),
    .opcode_i       (opcode_i),
    .chan_a_i       (chan_a_i),
    .chan_b_i       (chan_b_i),
    .chan_c_i       (chan_c_i),
    .alpha_i        (alpha_i),
    .last_pixel_i   (last_pixel_i),
    .table_select_i (table_select_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .req_o          (lut_req)
  );

  plcc_lut #(
    .TableEntries (TABLE_ENTRIES)
  ) u_lut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .req_i  (lut_req),
    .rsp_o  (lut_rsp)
  );

  plcc_density u_density (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .cfg_i       (cfg_q),
    .rsp_i       (lut_rsp),
    .out_valid_o (out_valid_o),
    .out_a_o     (out_a_o),
    .out_b_o     (out_b_o),
    .out_c_o     (out_c_o),
    .row_end_o   (row_end_o)
  );

`ifndef ASSERT_OFF
  a_write_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && lut_req.valid && lut_req.wr) |=> !lut_rsp.valid)
    else $error("table write produced a read word");

  a_pixel_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && lut_req.valid && !lut_req.wr) |=> lut_rsp.valid)
    else $error("pixel lost at the table stage");

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && lut_rsp.valid) |=> lut_rsp.valid)
    else $error("table read word dropped while the pipeline held");
`endif

endmodule

### tb/pixel_lut_color_convert_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_lut_color_convert_checker
// Watches the ports of the color converter and checks every output word.
// ----------------------------------------------------------------------------
// Keeps its own copy of the four lookup tables and the configuration, follows
// register writes and table writes as they are accepted, predicts the output
// word of every accepted pixel and compares it in order with what the block
// delivers. Reports the failure count and the number of pixels still owed.
// ----------------------------------------------------------------------------
module pixel_lut_color_convert_checker import plcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DensW-1:0]   cfg_wdata_i,

  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               opcode_i,
  input  logic [ChanW-1:0]   chan_a_i,
  input  logic [ChanW-1:0]   chan_b_i,
  input  logic [ChanW-1:0]   chan_c_i,
  input  logic [ChanW-1:0]   alpha_i,
  input  logic               last_pixel_i,
  input  logic [1:0]         table_select_i,
  input  logic [ChanW-1:0]   table_index_i,
  input  logic [ValW-1:0]    table_value_i,

  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [ValW-1:0]    out_a_i,
  input  logic [ValW-1:0]    out_b_i,
  input  logic [ValW-1:0]    out_c_i,
  input  logic               row_end_i,

  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  localparam int unsigned LutDepth = 256;

  typedef struct packed {
    logic [ValW-1:0] a;
    logic [ValW-1:0] b;
    logic [ValW-1:0] c;
    logic            last;
  } pix_result_t;

  logic [ValW-1:0] comp_lut  [LutDepth];
  logic [ValW-1:0] red_lut   [LutDepth];
  logic [ValW-1:0] green_lut [LutDepth];
  logic [ValW-1:0] blue_lut  [LutDepth];

  mode_e            cur_mode;
  logic             cur_alpha;
  logic [DensW-1:0] cur_density;
  logic             cur_mono;

  pix_result_t expected_pixels [$];
  pix_result_t want;
  int unsigned fails = 0;

  function automatic logic [ChanW-1:0] over_white(input logic [ChanW-1:0] v,
                                                  input logic [ChanW-1:0] a);
    int unsigned t;
    t = (int'(v) * int'(a)) / 255 + 255 - int'(a);
    return t[ChanW-1:0];
  endfunction

  // darken or lighten by the density gain, saturating at zero
  function automatic logic [ValW-1:0] ink_scale(input logic [ValW-1:0] v);
    logic [63:0] drop;
    drop = (64'(ValMax - v) * 64'(cur_density)) >> 16;
    if (drop >= 64'(ValMax)) begin
      return '0;
    end
    return ValW'(64'(ValMax) - drop);
  endfunction

  function automatic pix_result_t convert_pixel(input logic [ChanW-1:0] ca,
                                                input logic [ChanW-1:0] cb,
                                                input logic [ChanW-1:0] cc,
                                                input logic [ChanW-1:0] al,
                                                input logic last);
    pix_result_t     r;
    int unsigned     lum;
    logic [ChanW-1:0] ia;
    logic [ChanW-1:0] ib;
    logic [ChanW-1:0] ic;
    logic            scale;
    r = '0;
    ia = ca;
    ib = cb;
    ic = cc;
    case (cur_mode)
      MODE_RGB2RGB: begin
        if (cur_alpha) begin
          ia = over_white(ca, al);
          ib = over_white(cb, al);
          ic = over_white(cc, al);
        end
        r.a = red_lut[ia];
        r.b = green_lut[ib];
        r.c = blue_lut[ic];
        scale = cur_density < DensityUnity;
      end
      MODE_RGB2GRAY: begin
        lum = LumR * ca + LumG * cb + LumB * cc;
        if (cur_alpha) begin
          lum = lum * al / LumDiv + int'(ChanMax) - int'(al);
        end else begin
          lum = lum / 100;
        end
        r.a = comp_lut[lum[ChanW-1:0]];
        scale = !cur_mono;
      end
      MODE_GRAY2GRAY: begin
        if (cur_alpha) begin
          ia = over_white(ca, al);
        end
        r.a = comp_lut[ia];
        scale = !cur_mono;
      end
      default: begin
        if (cur_alpha) begin
          ia = over_white(ca, al);
        end
        r.a = red_lut[ia];
        r.b = green_lut[ia];
        r.c = blue_lut[ia];
        scale = 1'b1;
      end
    endcase
    if (scale) begin
      r.a = ink_scale(r.a);
      if (cur_mode == MODE_RGB2RGB || cur_mode == MODE_GRAY2RGB) begin
        r.b = ink_scale(r.b);
        r.c = ink_scale(r.c);
      end
    end
    r.last = last;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ValW-1:0] exp_v,
                             input logic [ValW-1:0] got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode = MODE_RGB2RGB;
      cur_alpha = 1'b0;
      cur_density = DensityUnity;
      cur_mono = 1'b0;
      expected_pixels.delete();
      pending_o <= 0;
      fail_count_o <= fails;
    end else begin
      // the word leaving now belongs to an older pixel than any entering now
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("output word with no pixel pending: out_a %0d out_b %0d out_c %0d",
                 out_a_i, out_b_i, out_c_i);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_a", want.a, out_a_i);
          check_field("out_b", want.b, out_b_i);
          check_field("out_c", want.c, out_c_i);
          check_field("row_end", ValW'(want.last), ValW'(row_end_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MODE:       cur_mode = mode_e'(cfg_wdata_i[1:0]);
          CFG_HAS_ALPHA:  cur_alpha = cfg_wdata_i[0];
          CFG_DENSITY:    cur_density = cfg_wdata_i;
          CFG_MONOCHROME: cur_mono = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_WRITE) begin
          case (tab_e'(table_select_i))
            TAB_COMP:  comp_lut[table_index_i] = table_value_i;
            TAB_RED:   red_lut[table_index_i] = table_value_i;
            TAB_GREEN: green_lut[table_index_i] = table_value_i;
            default:   blue_lut[table_index_i] = table_value_i;
          endcase
        end else begin
          expected_pixels.push_back(convert_pixel(chan_a_i, chan_b_i, chan_c_i,
                                                  alpha_i, last_pixel_i));
        end
      end
      pending_o <= expected_pixels.size();
      fail_count_o <= fails;
    end
  end

endmodule

### tb/pixel_lut_color_convert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_lut_color_convert_tb
// Stimulus and verdict for the pixel lookup color converter.
// ----------------------------------------------------------------------------
// Loads all four tables, runs a short directed set over the field extremes
// and every mode, then random mixes of pixels and table writes under a range
// of register settings. Both sides idle at random; the receiver holds off
// for a long stretch twice so that the pipeline fills and stalls its input.
// The checker beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module pixel_lut_color_convert_tb;
  import plcc_pkg::*;

  localparam int unsigned CycleLimit   = 3000000;
  localparam int unsigned DrainPause   = 12;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned HoldCycles   = 400;
  localparam logic [DensW-1:0] DensityMax = 18'd131072;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;

  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [DensW-1:0]   cfg_wdata = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = OP_CONVERT;
  logic [ChanW-1:0]   chan_a = '0;
  logic [ChanW-1:0]   chan_b = '0;
  logic [ChanW-1:0]   chan_c = '0;
  logic [ChanW-1:0]   alpha = '0;
  logic               last_pixel = 1'b0;
  logic [1:0]         table_select = '0;
  logic [ChanW-1:0]   table_index = '0;
  logic [ValW-1:0]    table_value = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ValW-1:0]    out_a;
  logic [ValW-1:0]    out_b;
  logic [ValW-1:0]    out_c;
  logic               row_end;

  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        cycle_count = 0;
  int unsigned        hold_ticket = 0;
  int unsigned        tx_calm = 0;

  pixel_lut_color_convert DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .chan_a_i       (chan_a),
    .chan_b_i       (chan_b),
    .chan_c_i       (chan_c),
    .alpha_i        (alpha),
    .last_pixel_i   (last_pixel),
    .table_select_i (table_select),
    .table_index_i  (table_index),
    .table_value_i  (table_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_a_o        (out_a),
    .out_b_o        (out_b),
    .out_c_o        (out_c),
    .row_end_o      (row_end)
  );

  pixel_lut_color_convert_checker pixel_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .opcode_i       (opcode),
    .chan_a_i       (chan_a),
    .chan_b_i       (chan_b),
    .chan_c_i       (chan_c),
    .alpha_i        (alpha),
    .last_pixel_i   (last_pixel),
    .table_select_i (table_select),
    .table_index_i  (table_index),
    .table_value_i  (table_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_a_i        (out_a),
    .out_b_i        (out_b),
    .out_c_i        (out_c),
    .row_end_i      (row_end),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL pixel_lut_color_convert");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ChanW-1:0] pick_chan();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return ChanMax;
    return ChanW'($urandom_range(0, 255));
  endfunction

  function automatic logic [DensW-1:0] pick_density();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return DensW'(DensityUnity - 1);
      2:       return DensityUnity;
      3:       return DensityMax;
      default: return DensW'($urandom_range(0, 131072));
    endcase
  endfunction

  // offer one word, hold it until taken, then at times idle for a while
  task automatic push_word(input logic op, input logic [ChanW-1:0] a,
                           input logic [ChanW-1:0] b, input logic [ChanW-1:0] c,
                           input logic [ChanW-1:0] al, input logic last,
                           input logic [1:0] sel, input logic [ChanW-1:0] idx,
                           input logic [ValW-1:0] val);
    int unsigned g;
    in_valid <= 1'b1;
    opcode <= op;
    chan_a <= a;
    chan_b <= b;
    chan_c <= c;
    alpha <= al;
    last_pixel <= last;
    table_select <= sel;
    table_index <= idx;
    table_value <= val;
    do @(posedge clk_i); while (in_stall);
    if (tx_calm > 0) begin
      tx_calm--;
      g = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) tx_calm = $urandom_range(20, 100);
      g = pick_gap();
    end
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_pixel(input logic [ChanW-1:0] a, input logic [ChanW-1:0] b,
                            input logic [ChanW-1:0] c, input logic [ChanW-1:0] al,
                            input logic last);
    push_word(OP_CONVERT, a, b, c, al, last, 2'($urandom_range(0, 3)),
              ChanW'($urandom_range(0, 255)), ValW'($urandom_range(0, 65535)));
  endtask

  task automatic send_entry(input tab_e sel, input logic [ChanW-1:0] idx,
                            input logic [ValW-1:0] val);
    push_word(OP_WRITE, ChanW'($urandom_range(0, 255)), ChanW'($urandom_range(0, 255)),
              ChanW'($urandom_range(0, 255)), ChanW'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), sel, idx, val);
  endtask

  // stop offering and wait for every owed pixel, then let table writes settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainPause) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DensW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic set_config(input mode_e m, input logic al, input logic [DensW-1:0] d,
                            input logic mono);
    drain();
    write_reg(CFG_MODE, DensW'(m));
    write_reg(CFG_HAS_ALPHA, DensW'(al));
    write_reg(CFG_DENSITY, d);
    write_reg(CFG_MONOCHROME, DensW'(mono));
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n, input bit hold);
    logic             hit;
    logic [ChanW-1:0] hit_idx;
    logic [ChanW-1:0] c;
    logic [ValW-1:0]  v;
    int unsigned      r;
    hit = 1'b0;
    hit_idx = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (hold && i == n / 4) hold_ticket++;
      r = $urandom_range(0, 99);
      if (r < 25) begin
        hit_idx = pick_chan();
        case ($urandom_range(0, 7))
          0:       v = '0;
          1:       v = ValMax;
          default: v = ValW'($urandom_range(0, 65535));
        endcase
        send_entry(tab_e'($urandom_range(0, 3)), hit_idx, v);
        hit = 1'b1;
      end else if (hit && $urandom_range(0, 2) == 0) begin
        // read back an entry just written
        send_pixel(hit_idx, hit_idx, hit_idx, pick_chan(), 1'($urandom_range(0, 1)));
        hit = 1'b0;
      end else begin
        c = pick_chan();
        send_pixel(c, pick_chan(), pick_chan(), pick_chan(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // receiver side: random stall runs, calm stretches and long hold-offs
  initial begin
    int unsigned n;
    int unsigned hold_seen;
    hold_seen = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else if ($urandom_range(0, 99) < 5) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 200)) @(posedge clk_i);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every entry of every table gets a value before any pixel reads it
    for (int t = 0; t < 4; t++) begin
      for (int i = 0; i < 256; i++) begin
        send_entry(tab_e'(t), ChanW'(i), ValW'($urandom_range(0, 65535)));
      end
    end

    // reset settings: unity density passes table values unchanged
    send_entry(TAB_RED, '0, '0);
    send_entry(TAB_GREEN, ChanMax, ValMax);
    send_entry(TAB_BLUE, 8'd128, 16'd4660);
    send_pixel('0, ChanMax, 8'd128, 8'd77, 1'b1);
    send_pixel(ChanMax, '0, '0, '0, 1'b0);
    send_pixel('0, '0, '0, ChanMax, 1'b1);
    send_pixel(ChanMax, ChanMax, ChanMax, 8'd3, 1'b0);

    // full transparency lands on white, full opacity keeps the pixel
    set_config(MODE_RGB2RGB, 1'b1, '0, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd50, '0, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd50, ChanMax, 1'b1);
    send_pixel(ChanMax, ChanMax, ChanMax, 8'd128, 1'b0);

    set_config(MODE_RGB2GRAY, 1'b1, DensityMax, 1'b0);
    send_pixel(ChanMax, ChanMax, ChanMax, ChanMax, 1'b1);
    send_pixel('0, '0, '0, '0, 1'b0);
    send_pixel('0, '0, '0, ChanMax, 1'b1);

    set_config(MODE_RGB2GRAY, 1'b0, DensityUnity, 1'b1);
    send_pixel(ChanMax, ChanMax, ChanMax, 8'd9, 1'b0);
    send_pixel('0, '0, '0, 8'd9, 1'b1);
    send_pixel(8'd17, 8'd200, 8'd3, 8'd9, 1'b0);

    // doubled density on a zero entry saturates
    set_config(MODE_GRAY2GRAY, 1'b0, DensityMax, 1'b0);
    send_pixel('0, 8'd1, 8'd2, 8'd3, 1'b0);
    send_pixel(ChanMax, 8'd1, 8'd2, 8'd3, 1'b1);
    send_entry(TAB_COMP, 8'd7, '0);
    send_pixel(8'd7, ChanMax, ChanMax, ChanMax, 1'b0);

    set_config(MODE_GRAY2RGB, 1'b1, DensW'(DensityUnity - 1), 1'b1);
    send_pixel(ChanMax, 8'd5, 8'd5, '0, 1'b0);
    send_pixel('0, 8'd5, 8'd5, ChanMax, 1'b1);
    send_pixel(8'd100, 8'd5, 8'd5, 8'd100, 1'b0);

    set_config(MODE_RGB2RGB, 1'b1, 18'd1000, 1'b0);
    run_random(PhaseItems, 1'b0);
    set_config(MODE_RGB2GRAY, 1'b1, DensityMax, 1'b0);
    run_random(PhaseItems, 1'b1);
    set_config(MODE_GRAY2GRAY, 1'b0, DensW'(DensityUnity - 1), 1'b1);
    run_random(PhaseItems, 1'b0);
    set_config(MODE_GRAY2RGB, 1'b1, DensW'(DensityUnity + 1), 1'b0);
    run_random(PhaseItems, 1'b0);
    set_config(MODE_RGB2RGB, 1'b0, DensityMax, 1'b1);
    run_random(PhaseItems, 1'b0);
    for (int p = 0; p < 5; p++) begin
      set_config(mode_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_density(),
                 1'($urandom_range(0, 1)));
      run_random(PhaseItems, p == 2);
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS pixel_lut_color_convert");
    end else begin
      $display("FAIL pixel_lut_color_convert");
    end
    $finish;
  end

endmodule
